@@ rtl/pmoi_pkg.sv @@
// ----------------------------------------------------------------------------
// Polygon moment of inertia package
// Payload types, controller commands and fixed widths shared by the block.
// ----------------------------------------------------------------------------
package pmoi_pkg;

	localparam int CoordW = 16;
	localparam int NumW = 54;
	localparam int DenW = 38;
	localparam int MassW = 32;
	localparam int InertiaW = 48;
	localparam int ProdW = NumW + MassW;
	localparam int DivW = DenW + 3;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_ZERO_AREA = 2'd1;
	localparam logic [1:0] STATUS_SATURATED = 2'd2;

	typedef struct packed {
		logic signed [CoordW-1:0] vertex_x;
		logic signed [CoordW-1:0] vertex_y;
		logic last_vertex;
	} vertex_word_t;

	typedef struct packed {
		logic [InertiaW-1:0] inertia;
		logic [1:0] status;
	} result_word_t;

	typedef struct packed {
		logic load_vertex;
		logic load_first;
		logic edge_open;
		logic edge_close;
		logic [2:0] step;
		logic clear;
		logic mul_start;
		logic div_start;
		logic div_step;
	} pmoi_cmd_t;

	typedef struct packed {
		logic den_zero;
		logic div_done;
	} pmoi_stat_t;

endpackage

@@ rtl/pmoi_datapath.sv @@
// ----------------------------------------------------------------------------
// Polygon moment of inertia datapath
// Vertex registers, accumulators, shared multiplier and restoring divider.
// ----------------------------------------------------------------------------
module pmoi_datapath (
	input logic clk,
	input logic arst_n,
	input pmoi_pkg::vertex_word_t vin,
	input logic [pmoi_pkg::MassW-1:0] body_mass,
	input pmoi_pkg::pmoi_cmd_t cmd,
	output pmoi_pkg::pmoi_stat_t stat,
	output pmoi_pkg::result_word_t res
);
	import pmoi_pkg::*;

	localparam int CntW = 7;
	localparam int DivCycles = ProdW;

	logic signed [CoordW-1:0] fx_q, fy_q, px_q, py_q, ax_q, ay_q, bx_q, by_q;
	logic [NumW-1:0] num_q;
	logic [DenW-1:0] den_q;
	logic signed [33:0] p_q;
	logic signed [35:0] t_q;
	logic signed [32:0] cr_q;
	logic [32:0] w_q;
	logic signed [CoordW-1:0] ma, mb;
	logic [65:0] wt;
	logic [ProdW-1:0] dividend_q;
	logic [DivW-1:0] rem_q, dvs_q;
	logic [DivW:0] rem_sh;
	logic rem_ge;
	logic [InertiaW-1:0] quo_q;
	logic sat_q;
	logic [CntW-1:0] dcnt_q;
	logic [63:0] mlo, mhi;

	always_comb begin
		ma = ax_q;
		mb = by_q;
		case (cmd.step)
			3'd0: begin ma = ax_q; mb = by_q; end
			3'd1: begin ma = bx_q; mb = ay_q; end
			3'd2: begin ma = ax_q; mb = ax_q + bx_q; end
			3'd3: begin ma = ay_q; mb = ay_q + by_q; end
			3'd4: begin ma = bx_q; mb = bx_q; end
			3'd5: begin ma = by_q; mb = by_q; end
			default: begin ma = ax_q; mb = by_q; end
		endcase
	end

	// The shared multiplier takes (a+b) as one operand so t needs fewer steps;
	// a+b wraps in 16 bits, so terms are formed with widened sums below.
	logic signed [16:0] sxa, sya;
	logic signed [33:0] wprod;
	always_comb begin
		sxa = 17'(ax_q) + 17'(bx_q);
		sya = 17'(ay_q) + 17'(by_q);
		case (cmd.step)
			3'd2: wprod = 34'(ax_q) * 34'(sxa);
			3'd3: wprod = 34'(ay_q) * 34'(sya);
			default: wprod = 34'(ma) * 34'(mb);
		endcase
	end

	assign wt = 66'(w_q) * 66'($unsigned(t_q));
	assign mlo = 64'(body_mass) * 64'(num_q[31:0]);
	assign mhi = 64'(body_mass) * 64'(num_q[NumW-1:32]);
	assign rem_sh = {rem_q, dividend_q[ProdW-1]};
	assign rem_ge = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.load_first) begin
			fx_q <= vin.vertex_x;
			fy_q <= vin.vertex_y;
		end
		if (cmd.load_vertex) begin
			px_q <= vin.vertex_x;
			py_q <= vin.vertex_y;
		end
		if (cmd.edge_open) begin
			ax_q <= px_q; ay_q <= py_q; bx_q <= vin.vertex_x; by_q <= vin.vertex_y;
		end else if (cmd.edge_close) begin
			ax_q <= px_q; ay_q <= py_q; bx_q <= fx_q; by_q <= fy_q;
		end
		case (cmd.step)
			3'd0: p_q <= wprod;
			3'd1: begin
				cr_q <= 33'(p_q) - 33'(wprod);
				t_q <= '0;
			end
			3'd2: begin
				w_q <= cr_q[32] ? 33'(-cr_q) : 33'(cr_q);
				t_q <= 36'(wprod);
			end
			3'd3, 3'd4: t_q <= t_q + 36'(wprod);
			3'd5: t_q <= t_q + 36'(wprod);
			default: ;
		endcase
		if (cmd.mul_start) begin
			dividend_q <= ProdW'(mlo) + ProdW'({mhi, 32'd0});
			dvs_q <= DivW'(den_q) * DivW'(6);
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[ProdW-2:0], 1'b0};
			if (rem_ge) rem_q <= DivW'(rem_sh - {1'b0, dvs_q});
			else rem_q <= rem_sh[DivW-1:0];
			if (!sat_q) begin
				if (quo_q[InertiaW-1]) begin
					sat_q <= 1'b1;
					quo_q <= '1;
				end else begin
					quo_q <= {quo_q[InertiaW-2:0], rem_ge};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			den_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.clear) begin
				num_q <= '0;
				den_q <= '0;
			end else if (cmd.step == 3'd6) begin
				num_q <= num_q + NumW'(wt >> 16);
				den_q <= den_q + DenW'(w_q);
			end
			if (cmd.div_start) dcnt_q <= CntW'(DivCycles);
			else if (cmd.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
		end
	end

	assign stat.den_zero = (den_q == '0);
	assign stat.div_done = (dcnt_q == CntW'(1)) && cmd.div_step;
	assign res.inertia = (den_q == '0) ? '0 : quo_q;
	assign res.status = (den_q == '0) ? STATUS_ZERO_AREA :
		(sat_q ? STATUS_SATURATED : STATUS_OK);

endmodule

@@ rtl/pmoi_ctrl.sv @@
// ----------------------------------------------------------------------------
// Polygon moment of inertia controller
// Sequences the per-edge steps, the final product and the divider.
// ----------------------------------------------------------------------------
module pmoi_ctrl #(
	parameter int MAX_VERTICES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic in_last,
	output logic out_valid,
	input logic out_stall,
	output pmoi_pkg::pmoi_cmd_t cmd,
	input pmoi_pkg::pmoi_stat_t stat
);
	import pmoi_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EDGE = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_OUT = 3'd4;
	localparam int CntW = 7;

	logic [2:0] state_q;
	logic [2:0] step_q;
	logic closing_q, last_q;
	logic [CntW-1:0] vcnt_q;
	logic acc, open_edge;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign open_edge = acc && vcnt_q != '0 && vcnt_q < CntW'(MAX_VERTICES);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.step = 3'd7;
		cmd.load_first = acc && vcnt_q == '0;
		cmd.load_vertex = acc && (vcnt_q == '0 || open_edge);
		cmd.edge_open = open_edge;
		cmd.edge_close = acc && !open_edge && in_last;
		if (state_q == S_EDGE) cmd.step = step_q;
		if (state_q == S_EDGE && step_q == 3'd6 && !closing_q && last_q)
			cmd.edge_close = 1'b1;
		cmd.mul_start = state_q == S_MUL;
		cmd.div_start = state_q == S_MUL;
		cmd.div_step = state_q == S_DIV;
		cmd.clear = out_valid && !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			closing_q <= 1'b0;
			last_q <= 1'b0;
			vcnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (acc) begin
					last_q <= in_last;
					if (vcnt_q == '0) vcnt_q <= CntW'(1);
					else if (open_edge) vcnt_q <= vcnt_q + 1'b1;
					if (open_edge || (in_last && vcnt_q != '0)) begin
						state_q <= S_EDGE;
						step_q <= '0;
						closing_q <= !open_edge;
					end else if (in_last) begin
						state_q <= S_MUL;
					end
				end
				S_EDGE: begin
					if (step_q == 3'd6) begin
						if (!closing_q && last_q) begin
							closing_q <= 1'b1;
							step_q <= '0;
						end else if (closing_q) state_q <= S_MUL;
						else state_q <= S_IDLE;
					end else step_q <= step_q + 1'b1;
				end
				S_MUL: state_q <= stat.den_zero ? S_OUT : S_DIV;
				S_DIV: if (stat.div_done) state_q <= S_OUT;
				S_OUT: if (!out_stall) begin
					state_q <= S_IDLE;
					vcnt_q <= '0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CntW'(MAX_VERTICES)) else $error("vertex count overflow");

endmodule

@@ rtl/polygon_moment_of_inertia.sv @@
// ----------------------------------------------------------------------------
// Polygon moment of inertia
// Accepts one vertex word per handshake and returns one result word per
// polygon.
// ----------------------------------------------------------------------------
// A vertex that opens an edge runs the edge steps on the one shared 16x17
// multiplier while input is stalled; the first vertex is only registered.
// The last vertex adds the closing edge; mass times numerator is formed and a
// restoring divider finds the quotient bit by bit, then offers the result.
module polygon_moment_of_inertia #(
	parameter int MAX_VERTICES = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pmoi_pkg::MassW-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input pmoi_pkg::vertex_word_t in_data,
	output logic out_valid,
	input logic out_stall,
	output pmoi_pkg::result_word_t out_data
);
	import pmoi_pkg::*;

	logic [MassW-1:0] mass_q;
	pmoi_cmd_t cmd;
	pmoi_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mass_q <= MassW'(65536);
		else if (cfg_we) mass_q <= cfg_data;
	end

	pmoi_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_last(in_data.last_vertex), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	pmoi_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .vin(in_data), .body_mass(mass_q),
		.cmd(cmd), .stat(stat), .res(out_data)
	);

endmodule
